@@ sv/ddgp_pkg.sv @@
// ----------------------------------------------------------------------------
// ddgp_pkg: shared types and constants for the go-to-point wheel speed block
// Fixed-point angle constants, CORDIC arctangent table, cell payload types.
// ----------------------------------------------------------------------------
package ddgp_pkg;

   localparam int ANG_W = 24;

   localparam logic signed [ANG_W-1:0] PI_Q16      = 24'sd205887;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 24'sd102944;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 24'sd411774;
   localparam logic signed [31:0]      INV_GAIN_Q30 = 32'sd652032874;

   localparam logic signed [11:0] FRONT_GAIN   = 12'sd1600;
   localparam logic signed [11:0] SIDE_GAIN    = 12'sd160;
   localparam logic signed [11:0] SPEED_MAX_Q4 = 12'sd1600;

   localparam logic signed [14:0] SPIN_FAST = 15'sd16000;
   localparam logic signed [14:0] SPIN_SLOW = 15'sd15520;
   localparam logic signed [14:0] PIVOT_BACK = 15'sd160;

   localparam logic signed [ANG_W-1:0] ATAN_TAB [16] = '{
      24'sd51472, 24'sd30386, 24'sd16055, 24'sd8150,
      24'sd4091,  24'sd2047,  24'sd1024,  24'sd512,
      24'sd256,   24'sd128,   24'sd64,    24'sd32,
      24'sd16,    24'sd8,     24'sd4,     24'sd2
   };

   typedef enum logic [2:0] {
      MODE_TRACK       = 3'd0,
      MODE_SPIN_LEFT   = 3'd1,
      MODE_SPIN_RIGHT  = 3'd2,
      MODE_PIVOT_LEFT  = 3'd3,
      MODE_PIVOT_RIGHT = 3'd4,
      MODE_TRACK_5     = 3'd5,
      MODE_TRACK_6     = 3'd6,
      MODE_TRACK_7     = 3'd7
   } mode_type;

   typedef struct packed {
      logic signed [31:0]      x;
      logic signed [31:0]      y;
      logic signed [ANG_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [21:0] rem;
      logic [20:0] root;
      logic [41:0] v;
   } sqrt_type;

   typedef struct packed {
      logic signed [15:0] hd;
      logic [3:0]         id;
      mode_type           mode;
      logic               dx_pos;
      logic               dx_neg;
      logic               dy_zero;
      logic               dy_pos;
      logic               neg;
   } meta_type;

endpackage

@@ sv/ddgp_vec_cell.sv @@
// ----------------------------------------------------------------------------
// ddgp_vec_cell: one CORDIC vectoring step
// Rotates (x, y) toward the x axis and accumulates the angle; registered.
// ----------------------------------------------------------------------------
module ddgp_vec_cell (
   input  logic                 clock,
   input  logic                 en,
   input  logic [3:0]           shift,
   input  ddgp_pkg::cordic_type cin,
   output ddgp_pkg::cordic_type cout
);

   ddgp_pkg::cordic_type cell_ff, cell_in;

   always_comb begin
      if (!cin.y[31]) begin
         cell_in.x = cin.x + (cin.y >>> shift);
         cell_in.y = cin.y - (cin.x >>> shift);
         cell_in.z = cin.z + ddgp_pkg::ATAN_TAB[shift];
      end else begin
         cell_in.x = cin.x - (cin.y >>> shift);
         cell_in.y = cin.y + (cin.x >>> shift);
         cell_in.z = cin.z - ddgp_pkg::ATAN_TAB[shift];
      end
   end

   always_ff @(posedge clock) begin
      if (en) cell_ff <= cell_in;
   end

   assign cout = cell_ff;

endmodule

@@ sv/ddgp_rot_cell.sv @@
// ----------------------------------------------------------------------------
// ddgp_rot_cell: one CORDIC rotation step
// Rotates (x, y) by the next table angle, driving the residual angle to zero.
// ----------------------------------------------------------------------------
module ddgp_rot_cell (
   input  logic                 clock,
   input  logic                 en,
   input  logic [3:0]           shift,
   input  ddgp_pkg::cordic_type cin,
   output ddgp_pkg::cordic_type cout
);

   ddgp_pkg::cordic_type cell_ff, cell_in;

   always_comb begin
      if (!cin.z[ddgp_pkg::ANG_W-1]) begin
         cell_in.x = cin.x - (cin.y >>> shift);
         cell_in.y = cin.y + (cin.x >>> shift);
         cell_in.z = cin.z - ddgp_pkg::ATAN_TAB[shift];
      end else begin
         cell_in.x = cin.x + (cin.y >>> shift);
         cell_in.y = cin.y - (cin.x >>> shift);
         cell_in.z = cin.z + ddgp_pkg::ATAN_TAB[shift];
      end
   end

   always_ff @(posedge clock) begin
      if (en) cell_ff <= cell_in;
   end

   assign cout = cell_ff;

endmodule

@@ sv/ddgp_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// ddgp_sqrt_cell: one restoring square root digit
// Brings in the next two radicand bits and decides one root bit; registered.
// ----------------------------------------------------------------------------
module ddgp_sqrt_cell (
   input  logic               clock,
   input  logic               en,
   input  ddgp_pkg::sqrt_type cin,
   output ddgp_pkg::sqrt_type cout
);

   ddgp_pkg::sqrt_type cell_ff, cell_in;
   logic [23:0] part;
   logic [23:0] trial;

   always_comb begin
      part  = {cin.rem, cin.v[41:40]};
      trial = {1'b0, cin.root, 2'b01};
      cell_in.v = {cin.v[39:0], 2'b00};
      if (part >= trial) begin
         cell_in.rem  = 22'(part - trial);
         cell_in.root = {cin.root[19:0], 1'b1};
      end else begin
         cell_in.rem  = part[21:0];
         cell_in.root = {cin.root[19:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) cell_ff <= cell_in;
   end

   assign cout = cell_ff;

endmodule

@@ sv/diff_drive_goto_point_wheel_speeds.sv @@
// ----------------------------------------------------------------------------
// diff_drive_goto_point_wheel_speeds: go-to-point wheel speed pipeline
// One item per cycle while a stalled response does not hold the pipeline.
// Depth is set by the vectoring CORDIC row (16 cells), the rotation CORDIC
// row (16 cells) and the speed multiply stages; the sqrt row runs alongside.
// Reset clears all stage valid bits; the whole pipeline holds while a valid response meets rsp_stall.
// ----------------------------------------------------------------------------
module diff_drive_goto_point_wheel_speeds (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_robot_x,
   input  logic signed [15:0] req_robot_y,
   input  logic signed [15:0] req_heading,
   input  logic [3:0]         req_robot_number,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic [2:0]         req_drive_mode,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_left_speed,
   output logic signed [14:0] rsp_right_speed
);

   localparam int DEPTH = 39;
   localparam int ML    = 37;
   localparam int DL    = 12;

   logic en;
   logic [DEPTH-1:0] vld_ff;

   // stage A
   logic signed [16:0] a_dx_ff, a_dy_ff;
   ddgp_pkg::meta_type a_meta_ff;

   // stage B
   ddgp_pkg::cordic_type vec_sig [17];
   ddgp_pkg::sqrt_type   sq_sig [22];
   ddgp_pkg::cordic_type b_vec_in;
   ddgp_pkg::sqrt_type   b_sq_in;
   ddgp_pkg::meta_type   b_meta_in;
   ddgp_pkg::meta_type   meta_ff [ML];
   logic signed [16:0]   b_xabs, b_yabs;
   logic [33:0]          b_sqsum;

   // stage C
   ddgp_pkg::cordic_type rot_sig [17];
   ddgp_pkg::cordic_type c_rot_in;
   ddgp_pkg::meta_type   c_meta;
   logic signed [ddgp_pkg::ANG_W-1:0] c_ang, c_err, c_wrap;
   logic c_neg;

   logic [20:0] dist_ff [DL];

   // stages D to G
   logic signed [31:0] d_c_ff, d_c_in, d_s_in;
   logic signed [53:0] d_dc_ff, d_dc_in;
   logic signed [39:0] d_sp_ff, d_sp_in;
   logic signed [49:0] e_fp_ff, e_fp_in;
   logic signed [39:0] e_sp_ff;
   logic signed [19:0] f_fr, f_sr;
   logic signed [11:0] f_front_ff, f_front_in, f_side_ff, f_side_in;
   logic signed [12:0] g_l, g_r;
   logic signed [14:0] g_left_in, g_right_in, g_left_ff, g_right_ff;

   assign en        = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_dx_ff <= 17'(req_target_x) - 17'(req_robot_x);
         a_dy_ff <= 17'(req_target_y) - 17'(req_robot_y);
         a_meta_ff.hd      <= req_heading;
         a_meta_ff.id      <= req_robot_number;
         a_meta_ff.mode    <= ddgp_pkg::mode_type'(req_drive_mode);
         a_meta_ff.dx_pos  <= 1'b0;
         a_meta_ff.dx_neg  <= 1'b0;
         a_meta_ff.dy_zero <= 1'b0;
         a_meta_ff.dy_pos  <= 1'b0;
         a_meta_ff.neg     <= 1'b0;
      end
   end

   // flags, vectoring start point and radicand
   always_comb begin
      b_meta_in         = a_meta_ff;
      b_meta_in.dx_pos  = !a_dx_ff[16] && (a_dx_ff != '0);
      b_meta_in.dx_neg  = a_dx_ff[16];
      b_meta_in.dy_zero = (a_dy_ff == '0);
      b_meta_in.dy_pos  = !a_dy_ff[16] && (a_dy_ff != '0);
      b_xabs = a_dx_ff[16] ? -a_dx_ff : a_dx_ff;
      b_yabs = a_dx_ff[16] ? -a_dy_ff : a_dy_ff;
      b_vec_in.x = 32'(b_xabs) <<< 12;
      b_vec_in.y = 32'(b_yabs) <<< 12;
      b_vec_in.z = '0;
      b_sqsum = 34'(34'(a_dx_ff) * 34'(a_dx_ff)) + 34'(34'(a_dy_ff) * 34'(a_dy_ff));
      b_sq_in.v    = {b_sqsum, 8'b0};
      b_sq_in.rem  = '0;
      b_sq_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_sig[0] <= b_vec_in;
         sq_sig[0]  <= b_sq_in;
      end
   end

   for (genvar g = 0; g < 16; g++) begin : g_vec
      ddgp_vec_cell u_vec (
         .clock (clock),
         .en    (en),
         .shift (4'(g)),
         .cin   (vec_sig[g]),
         .cout  (vec_sig[g+1])
      );
   end

   for (genvar g = 0; g < 21; g++) begin : g_sqrt
      ddgp_sqrt_cell u_sqrt (
         .clock (clock),
         .en    (en),
         .cin   (sq_sig[g]),
         .cout  (sq_sig[g+1])
      );
   end

   // target angle, heading error, wrap and fold into [-pi/2, pi/2]
   always_comb begin
      if (meta_ff[16].dx_pos) begin
         c_ang = meta_ff[16].dy_zero ? '0 : vec_sig[16].z;
      end else if (meta_ff[16].dx_neg) begin
         c_ang = ddgp_pkg::PI_Q16 + (meta_ff[16].dy_zero ? '0 : vec_sig[16].z);
      end else if (meta_ff[16].dy_pos) begin
         c_ang = ddgp_pkg::PI_Q16 + ddgp_pkg::HALF_PI_Q16;
      end else if (meta_ff[16].dy_zero) begin
         c_ang = ddgp_pkg::PI_Q16;
      end else begin
         c_ang = ddgp_pkg::PI_Q16 - ddgp_pkg::HALF_PI_Q16;
      end
      c_err = c_ang - (24'(meta_ff[16].hd) <<< 3);
      if (c_err > ddgp_pkg::PI_Q16) begin
         c_wrap = c_err - ddgp_pkg::TWO_PI_Q16;
      end else if (c_err < -ddgp_pkg::PI_Q16) begin
         c_wrap = c_err + ddgp_pkg::TWO_PI_Q16;
      end else begin
         c_wrap = c_err;
      end
      c_rot_in.x = ddgp_pkg::INV_GAIN_Q30;
      c_rot_in.y = '0;
      if (c_wrap > ddgp_pkg::HALF_PI_Q16) begin
         c_rot_in.z = c_wrap - ddgp_pkg::PI_Q16;
         c_neg = 1'b1;
      end else if (c_wrap < -ddgp_pkg::HALF_PI_Q16) begin
         c_rot_in.z = c_wrap + ddgp_pkg::PI_Q16;
         c_neg = 1'b1;
      end else begin
         c_rot_in.z = c_wrap;
         c_neg = 1'b0;
      end
      c_meta     = meta_ff[16];
      c_meta.neg = c_neg;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= b_meta_in;
         for (int k = 1; k < ML; k++) begin
            if (k == 17) meta_ff[k] <= c_meta;
            else meta_ff[k] <= meta_ff[k-1];
         end
         rot_sig[0] <= c_rot_in;
         dist_ff[0] <= sq_sig[21].root;
         for (int k = 1; k < DL; k++) dist_ff[k] <= dist_ff[k-1];
      end
   end

   for (genvar g = 0; g < 16; g++) begin : g_rot
      ddgp_rot_cell u_rot (
         .clock (clock),
         .en    (en),
         .shift (4'(g)),
         .cin   (rot_sig[g]),
         .cout  (rot_sig[g+1])
      );
   end

   always_comb begin
      d_c_in  = meta_ff[33].neg ? -rot_sig[16].x : rot_sig[16].x;
      d_s_in  = meta_ff[33].neg ? -rot_sig[16].y : rot_sig[16].y;
      d_dc_in = 54'($signed({1'b0, dist_ff[DL-1]})) * 54'(d_c_in);
      d_sp_in = 40'(d_s_in) * 40'(ddgp_pkg::SIDE_GAIN);
   end

   always_comb begin
      if (meta_ff[34].id == 4'd1) begin
         e_fp_in = 50'(d_c_ff) * 50'(ddgp_pkg::FRONT_GAIN);
      end else begin
         e_fp_in = 50'(38'(d_dc_ff >>> 16)) * 50'(ddgp_pkg::FRONT_GAIN);
      end
   end

   // round half up to Q.4 and clamp
   always_comb begin
      f_fr = 20'((e_fp_ff + (50'sd1 <<< 29)) >>> 30);
      f_sr = 20'((e_sp_ff + (40'sd1 <<< 29)) >>> 30);
      if (f_fr > 20'(ddgp_pkg::SPEED_MAX_Q4)) f_front_in = ddgp_pkg::SPEED_MAX_Q4;
      else if (f_fr < -20'(ddgp_pkg::SPEED_MAX_Q4)) f_front_in = -ddgp_pkg::SPEED_MAX_Q4;
      else f_front_in = 12'(f_fr);
      if (f_sr > 20'(ddgp_pkg::SPEED_MAX_Q4)) f_side_in = ddgp_pkg::SPEED_MAX_Q4;
      else if (f_sr < -20'(ddgp_pkg::SPEED_MAX_Q4)) f_side_in = -ddgp_pkg::SPEED_MAX_Q4;
      else f_side_in = 12'(f_sr);
   end

   // mix wheels, clamp, then apply the fixed modes
   always_comb begin
      if (!f_front_ff[11] && (f_front_ff != '0)) begin
         g_l = 13'(f_front_ff) - 13'(f_side_ff);
         g_r = 13'(f_front_ff) + 13'(f_side_ff);
      end else begin
         g_l = 13'(f_front_ff) + 13'(f_side_ff);
         g_r = 13'(f_front_ff) - 13'(f_side_ff);
      end
      if (g_l > 13'(ddgp_pkg::SPEED_MAX_Q4)) g_left_in = 15'(ddgp_pkg::SPEED_MAX_Q4);
      else if (g_l < -13'(ddgp_pkg::SPEED_MAX_Q4)) g_left_in = -15'(ddgp_pkg::SPEED_MAX_Q4);
      else g_left_in = 15'(g_l);
      if (g_r > 13'(ddgp_pkg::SPEED_MAX_Q4)) g_right_in = 15'(ddgp_pkg::SPEED_MAX_Q4);
      else if (g_r < -13'(ddgp_pkg::SPEED_MAX_Q4)) g_right_in = -15'(ddgp_pkg::SPEED_MAX_Q4);
      else g_right_in = 15'(g_r);
      unique case (meta_ff[36].mode)
         ddgp_pkg::MODE_SPIN_LEFT: begin
            g_left_in  = -ddgp_pkg::SPIN_FAST;
            g_right_in = ddgp_pkg::SPIN_SLOW;
         end
         ddgp_pkg::MODE_SPIN_RIGHT: begin
            g_left_in  = ddgp_pkg::SPIN_SLOW;
            g_right_in = -ddgp_pkg::SPIN_FAST;
         end
         ddgp_pkg::MODE_PIVOT_LEFT: begin
            g_left_in  = '0;
            g_right_in = -ddgp_pkg::PIVOT_BACK;
         end
         ddgp_pkg::MODE_PIVOT_RIGHT: begin
            g_left_in  = ddgp_pkg::SPIN_FAST;
            g_right_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_c_ff     <= d_c_in;
         d_dc_ff    <= d_dc_in;
         d_sp_ff    <= d_sp_in;
         e_fp_ff    <= e_fp_in;
         e_sp_ff    <= d_sp_ff;
         f_front_ff <= f_front_in;
         f_side_ff  <= f_side_in;
         g_left_ff  <= g_left_in;
         g_right_ff <= g_right_in;
      end
   end

   assign rsp_valid       = vld_ff[DEPTH-1];
   assign rsp_left_speed  = g_left_ff;
   assign rsp_right_speed = g_right_ff;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the go-to-point wheel speed pipeline
// Feeds poses, targets and drive modes through the valid/stall request port.
// Predicts wheel speeds with an independent fixed-point CORDIC model and
// checks each response in order. Random idling on both sides, plus one long
// response hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic signed [15:0]   rx;
      logic signed [15:0]   ry;
      logic signed [15:0]   hd;
      logic [3:0]           id;
      logic signed [15:0]   tx;
      logic signed [15:0]   ty;
      ddgp_pkg::mode_type   mode;
   } pose_cmd_type;

   typedef struct packed {
      logic signed [14:0] left;
      logic signed [14:0] right;
   } wheel_pair_type;

   localparam int HOLD_LEN   = 300;
   localparam int WATCH_LIM  = 2000;
   localparam int DRAIN_WAIT = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_robot_x = '0, req_robot_y = '0, req_heading = '0;
   logic [3:0] req_robot_number = '0;
   logic signed [15:0] req_target_x = '0, req_target_y = '0;
   logic [2:0] req_drive_mode = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [14:0] rsp_left_speed, rsp_right_speed;
   logic req_stall_q = 1'b0;

   pose_cmd_type   cmd_queue[$];
   wheel_pair_type speed_expect[$];
   int errors = 0;
   int sent = 0;
   int rcvd = 0;
   int mode_seen[8];
   bit stim_done = 0;
   bit quiet_phase = 0;
   int hold_left = 0;
   bit hold_used = 0;
   int idle_cycles = 0;

   diff_drive_goto_point_wheel_speeds dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint atan_vec(longint x, longint y);
      longint z = 0, xs, ys;
      for (int i = 0; i < 16; i++) begin
         xs = asr(x, i);
         ys = asr(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(ddgp_pkg::ATAN_TAB[i]);
         end else begin
            x -= ys; y += xs; z -= longint'(ddgp_pkg::ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic void rotate_cs(longint a, output longint c, output longint s);
      longint x = 652032874, y = 0, xs, ys;
      bit flip = 0;
      if (a > 102944) begin
         a -= 205887; flip = 1;
      end else if (a < -102944) begin
         a += 205887; flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         xs = asr(x, i);
         ys = asr(y, i);
         if (a >= 0) begin
            x -= ys; y += xs; a -= longint'(ddgp_pkg::ATAN_TAB[i]);
         end else begin
            x += ys; y -= xs; a += longint'(ddgp_pkg::ATAN_TAB[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint int_root(longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint round_q4(longint v);
      return asr(v + (64'sd1 <<< 29), 30);
   endfunction

   function automatic wheel_pair_type wheel_speeds(pose_cmd_type p);
      longint dx, dy, ang, err, c, s, front, side, l, r, span;
      wheel_pair_type w;
      dx = longint'(p.tx) - longint'(p.rx);
      dy = longint'(p.ty) - longint'(p.ry);
      if (dx > 0)
         ang = (dy == 0) ? 0 : atan_vec(dx * 4096, dy * 4096);
      else if (dx < 0)
         ang = 205887 + ((dy == 0) ? 0 : atan_vec(-dx * 4096, -dy * 4096));
      else
         ang = 205887 + (dy > 0 ? 102944 : (dy < 0 ? -102944 : 0));
      err = ang - longint'(p.hd) * 8;
      if (err > 205887) err -= 411774;
      else if (err < -205887) err += 411774;
      rotate_cs(err, c, s);
      if (p.id == 4'd1) front = round_q4(c * 1600);
      else begin
         span = int_root((dx * dx + dy * dy) << 8);
         front = round_q4(asr(span * c, 16) * 1600);
      end
      front = clip(front, 1600);
      side = clip(round_q4(s * 160), 1600);
      if (front > 0) begin
         l = front - side; r = front + side;
      end else begin
         l = front + side; r = front - side;
      end
      l = clip(l, 1600);
      r = clip(r, 1600);
      case (p.mode)
         ddgp_pkg::MODE_SPIN_LEFT: begin l = -16000; r = 15520; end
         ddgp_pkg::MODE_SPIN_RIGHT: begin l = 15520; r = -16000; end
         ddgp_pkg::MODE_PIVOT_LEFT: begin l = 0; r = -160; end
         ddgp_pkg::MODE_PIVOT_RIGHT: begin l = 16000; r = 0; end
         default: ;
      endcase
      w.left = l[14:0];
      w.right = r[14:0];
      return w;
   endfunction

   function automatic logic signed [15:0] pick16();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'($urandom_range(0, 64)) - 16'sd32;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pose_cmd_type rand_cmd();
      pose_cmd_type p;
      p.rx = pick16();
      p.ry = pick16();
      p.hd = 16'($urandom);
      p.id = 4'($urandom);
      p.tx = ($urandom_range(0, 5) == 0) ? p.rx : pick16();
      p.ty = ($urandom_range(0, 5) == 0) ? p.ry : pick16();
      p.mode = ddgp_pkg::mode_type'($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) :
                          ($urandom_range(0, 1) ? 0 : $urandom_range(0, 7)));
      return p;
   endfunction

   function automatic pose_cmd_type mk(int rx, int ry, int hd, int id, int tx, int ty,
                                       ddgp_pkg::mode_type m);
      pose_cmd_type p;
      p.rx = 16'(rx); p.ry = 16'(ry); p.hd = 16'(hd); p.id = 4'(id);
      p.tx = 16'(tx); p.ty = 16'(ty); p.mode = m;
      return p;
   endfunction

   initial begin
      // directed: axes, coincident points, extremes, every mode, error at +-pi
      cmd_queue.push_back(mk(0, 0, 0, 0, 4096, 0, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(0, 0, 0, 1, 4096, 0, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(0, 0, 0, 2, -4096, 0, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(0, 0, 0, 3, 0, 4096, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(0, 0, 0, 4, 0, -4096, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(100, 100, 0, 0, 100, 100, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(100, 100, 25736, 1, 100, 100, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(-32768, -32768, 32767, 15, 32767, 32767,
                             ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(32767, 32767, -32768, 0, -32768, -32768,
                             ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(32767, -32768, -32768, 1, -32768, 32767,
                             ddgp_pkg::MODE_TRACK_5));
      cmd_queue.push_back(mk(0, 0, 25736, 7, 4096, 100, ddgp_pkg::MODE_TRACK_6));
      cmd_queue.push_back(mk(0, 0, -25736, 8, -4096, 3, ddgp_pkg::MODE_TRACK_7));
      cmd_queue.push_back(mk(1, 2, 3, 0, 5, 6, ddgp_pkg::MODE_SPIN_LEFT));
      cmd_queue.push_back(mk(1, 2, 3, 0, 5, 6, ddgp_pkg::MODE_SPIN_RIGHT));
      cmd_queue.push_back(mk(1, 2, 3, 0, 5, 6, ddgp_pkg::MODE_PIVOT_LEFT));
      cmd_queue.push_back(mk(1, 2, 3, 0, 5, 6, ddgp_pkg::MODE_PIVOT_RIGHT));
      cmd_queue.push_back(mk(0, 0, 12868, 1, 0, 4096, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(0, 0, -12868, 1, 0, 4096, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(0, 0, 0, 1, -4096, 1, ddgp_pkg::MODE_TRACK));
      cmd_queue.push_back(mk(0, 0, 0, 1, -4096, -1, ddgp_pkg::MODE_TRACK));
      for (int i = 0; i < 1500; i++) cmd_queue.push_back(rand_cmd());
      repeat (4) @(posedge clock);
      @(negedge clock) reset = 1'b0;
   end

   // driver: offer on the falling edge, advance after a transfer
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_q) begin
            sent++;
         end
         if (!req_valid || !req_stall_q) begin
            if (cmd_queue.size() != 0 && (quiet_phase || $urandom_range(0, 99) >= 38)) begin
               pose_cmd_type p;
               p = cmd_queue.pop_front();
               req_robot_x <= p.rx; req_robot_y <= p.ry; req_heading <= p.hd;
               req_robot_number <= p.id; req_target_x <= p.tx; req_target_y <= p.ty;
               req_drive_mode <= p.mode;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               if (cmd_queue.size() == 0) stim_done = 1;
            end
         end
      end
   end

   // stall seen at the last rising edge, so the driver knows if it was taken
   always @(posedge clock) req_stall_q <= req_stall;

   // predict at the transfer edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pose_cmd_type p;
         p = {req_robot_x, req_robot_y, req_heading, req_robot_number,
              req_target_x, req_target_y, ddgp_pkg::mode_type'(req_drive_mode)};
         speed_expect.push_back(wheel_speeds(p));
         mode_seen[req_drive_mode]++;
      end
   end

   // response stall: random, one long hold-off, and a quiet stretch
   always @(negedge clock) begin
      if (!reset) begin
         quiet_phase <= (sent > 600 && sent < 900);
         if (!hold_used && sent > 300) begin
            hold_used <= 1;
            hold_left <= HOLD_LEN;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= !quiet_phase && ($urandom_range(0, 99) < 38);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         wheel_pair_type w;
         rcvd++;
         if (speed_expect.size() == 0) begin
            $error("unexpected response left=%0d right=%0d", rsp_left_speed,
                   rsp_right_speed);
            errors++;
         end else begin
            w = speed_expect.pop_front();
            if (rsp_left_speed !== w.left) begin
               $error("left_speed expected %0d got %0d", w.left, rsp_left_speed);
               errors++;
            end
            if (rsp_right_speed !== w.right) begin
               $error("right_speed expected %0d got %0d", w.right, rsp_right_speed);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCH_LIM) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      wait (stim_done && !req_valid);
      wait (speed_expect.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (speed_expect.size() != 0) begin
         $error("%0d responses missing", speed_expect.size());
         errors++;
      end
      $display("Covered %0d requests, %0d responses; per mode %0d %0d %0d %0d %0d %0d %0d %0d",
               sent, rcvd, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
               mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7]);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

@@ sim.f @@
sv/ddgp_pkg.sv
sv/ddgp_vec_cell.sv
sv/ddgp_rot_cell.sv
sv/ddgp_sqrt_cell.sv
sv/diff_drive_goto_point_wheel_speeds.sv
tb/tb_top.sv
